### rtl/eml_pkg.sv
// shared types, constants and codes for the extent map lookup block
`timescale 1ns / 1ps
`default_nettype none

package eml_pkg;

   // parameter defaults
   localparam int EXTENTS_DEF     = 8;
   localparam int BLOCK_SHIFT_DEF = 10;

   // field widths
   localparam int INDEX_W  = 3;
   localparam int START_W  = 32;
   localparam int LENGTH_W = 16;
   localparam int OFFSET_W = 48;
   localparam int REMAIN_W = 26;
   // running byte total, one bit above the offset so the compare never wraps
   localparam int SUM_W    = OFFSET_W + 1;

   // item action codes
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // result status codes
   localparam logic ST_FOUND = 1'b0;
   localparam logic ST_MISS  = 1'b1;

   typedef struct packed {
      logic                action;
      logic [INDEX_W-1:0]  entry_index;
      logic [START_W-1:0]  entry_block;
      logic [LENGTH_W-1:0] entry_length;
      logic [OFFSET_W-1:0] offset;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [START_W-1:0]  block_number;
      logic [OFFSET_W-1:0] byte_address;
      logic [REMAIN_W-1:0] bytes_remaining;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic write;   // store the load item into its slot
      logic start;   // latch the lookup offset, clear the running total
      logic walk;    // examine the slot whose read data is present
      logic diff;    // form offset within extent and bytes left
      logic emit;    // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;     // offset falls inside the current slot
      logic empty;   // current slot has zero length
   } sts_type;

endpackage

`default_nettype wire

### rtl/eml_ctrl.sv
// controller for the extent map lookup: slot walk sequencing and result handshake
`timescale 1ns / 1ps
`default_nettype none

module eml_ctrl #(
   parameter int EXTENTS = eml_pkg::EXTENTS_DEF,
   parameter int IDX_W   = (EXTENTS > 1) ? $clog2(EXTENTS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_action,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output eml_pkg::cmd_type       cmd,
   input  wire eml_pkg::sts_type  sts,
   output logic [IDX_W-1:0]       rd_addr
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_WALK,
      S_DIFF,
      S_DONE
   } state_type;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(EXTENTS - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             last;
   logic             out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign last      = (slot_ff == LAST_SLOT);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // read address: slot 0 on entry, then one ahead of the slot being examined
   always_comb begin
      rd_addr = '0;
      if (state_ff == S_WALK && !last) begin
         rd_addr = slot_ff + 1'b1;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == eml_pkg::ACT_LOOKUP) begin
                  cmd.start = 1'b1;
                  state_in  = S_FIRST;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         S_FIRST: begin
            slot_in  = '0;
            state_in = S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (sts.hit || sts.empty || last) begin
               state_in = S_DIFF;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a result is only loaded when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result loaded over a waiting item");

   // a loaded result is offered on the next cycle
   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("loaded result not offered");

   // an accepted lookup starts the slot walk
   a_lookup_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == eml_pkg::ACT_LOOKUP) |=> (state_ff == S_FIRST))
      else $error("lookup did not start walk");

   // the walk never runs past the last slot
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (slot_ff <= LAST_SLOT))
      else $error("slot counter out of range");

   // no work item is taken while a lookup is in flight
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK || state_ff == S_DIFF) |-> !cmd.write && !cmd.start)
      else $error("item taken while busy");

endmodule

`default_nettype wire

### rtl/eml_dpath.sv
// datapath for the extent map lookup: extent store, running total and result register
`timescale 1ns / 1ps
`default_nettype none

module eml_dpath #(
   parameter int EXTENTS     = eml_pkg::EXTENTS_DEF,
   parameter int BLOCK_SHIFT = eml_pkg::BLOCK_SHIFT_DEF,
   parameter int IDX_W       = (EXTENTS > 1) ? $clog2(EXTENTS) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire eml_pkg::req_type  req_item,
   input  wire eml_pkg::cmd_type  cmd,
   output eml_pkg::sts_type       sts,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output eml_pkg::rsp_type       rsp_item
);

   localparam int SUM_W    = eml_pkg::SUM_W;
   localparam int OFFSET_W = eml_pkg::OFFSET_W;
   localparam int REMAIN_W = eml_pkg::REMAIN_W;
   localparam int START_W  = eml_pkg::START_W;
   localparam int LENGTH_W = eml_pkg::LENGTH_W;
   localparam int WIDE_W   = 7;

   // extent store
   logic [START_W-1:0]  start_mem [EXTENTS];
   logic [LENGTH_W-1:0] blocks_mem [EXTENTS];
   logic [EXTENTS-1:0]  valid_ff;

   logic [WIDE_W-1:0]   idx_wide;
   logic [IDX_W-1:0]    wr_addr;
   logic                wr_en;

   logic [START_W-1:0]  rd_start_ff;
   logic [LENGTH_W-1:0] rd_blocks_ff;
   logic                rd_valid_ff;
   logic [LENGTH_W-1:0] blocks_eff;

   logic [OFFSET_W-1:0] offset_ff;
   logic [SUM_W-1:0]    base_ff;
   logic [SUM_W-1:0]    end_ff;
   logic [START_W-1:0]  hit_start_ff;
   logic                found_ff;
   logic [OFFSET_W-1:0] rel_ff;
   logic [REMAIN_W-1:0] left_ff;
   eml_pkg::rsp_type    rsp_ff;

   logic [SUM_W-1:0]    bytes;
   logic [SUM_W-1:0]    sum;
   logic [SUM_W-1:0]    off_wide;
   logic [SUM_W-1:0]    left_wide;
   logic [OFFSET_W-1:0] start_bytes;

   // write address, load items beyond the table are dropped
   assign idx_wide = WIDE_W'(req_item.entry_index);
   assign wr_addr  = idx_wide[IDX_W-1:0];
   assign wr_en    = cmd.write && (idx_wide < WIDE_W'(EXTENTS));

   // store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         start_mem[wr_addr]  <= req_item.entry_block;
         blocks_mem[wr_addr] <= req_item.entry_length;
      end
      rd_start_ff  <= start_mem[rd_addr];
      rd_blocks_ff <= blocks_mem[rd_addr];
      rd_valid_ff  <= valid_ff[rd_addr];
   end

   // written flags, an unwritten slot reads as zero length
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign blocks_eff = rd_valid_ff ? rd_blocks_ff : '0;

   // slot compare: does the offset end before this extent does
   assign bytes     = SUM_W'(blocks_eff) << BLOCK_SHIFT;
   assign sum       = base_ff + bytes;
   assign off_wide  = SUM_W'(offset_ff);
   assign sts.empty = (blocks_eff == '0);
   assign sts.hit   = !sts.empty && (sum > off_wide);

   // bytes left in the extent
   assign left_wide   = end_ff - off_wide;
   assign start_bytes = OFFSET_W'(hit_start_ff) << BLOCK_SHIFT;

   // walk state
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         offset_ff <= req_item.offset;
         base_ff   <= '0;
         found_ff  <= 1'b0;
      end else if (cmd.walk) begin
         if (sts.hit) begin
            end_ff       <= sum;
            hit_start_ff <= rd_start_ff;
            found_ff     <= 1'b1;
         end else if (!sts.empty) begin
            base_ff <= sum;
         end
      end
      if (cmd.diff) begin
         rel_ff <= offset_ff - base_ff[OFFSET_W-1:0];
         if (|left_wide[SUM_W-1:REMAIN_W]) begin
            left_ff <= '1;
         end else begin
            left_ff <= left_wide[REMAIN_W-1:0];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (found_ff) begin
            rsp_ff.status          <= eml_pkg::ST_FOUND;
            rsp_ff.block_number    <= hit_start_ff;
            rsp_ff.byte_address    <= start_bytes + rel_ff;
            rsp_ff.bytes_remaining <= left_ff;
         end else begin
            rsp_ff.status          <= eml_pkg::ST_MISS;
            rsp_ff.block_number    <= '0;
            rsp_ff.byte_address    <= '0;
            rsp_ff.bytes_remaining <= '0;
         end
      end
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

### rtl/extent_map_lookup_core.sv
// extent map lookup: top level joining controller and datapath
// load item: no result, the block stays idle so the next item may follow in the next cycle
// lookup item: latch offset, read slot 0, walk 1..EXTENTS slots, then form the result
// one slot a cycle through the store's registered read port
// a new item is taken only once the previous lookup has handed its result to the output register
// reset is synchronous: clears all slot written flags (empty list), no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module extent_map_lookup_core #(
   parameter int EXTENTS     = eml_pkg::EXTENTS_DEF,
   parameter int BLOCK_SHIFT = eml_pkg::BLOCK_SHIFT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire eml_pkg::req_type  req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output eml_pkg::rsp_type       rsp_item
);

   localparam int IDX_W = (EXTENTS > 1) ? $clog2(EXTENTS) : 1;

   eml_pkg::cmd_type cmd;
   eml_pkg::sts_type sts;
   logic [IDX_W-1:0] rd_addr;

   // sequencing
   eml_ctrl #(
      .EXTENTS (EXTENTS),
      .IDX_W   (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_item.action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts),
      .rd_addr    (rd_addr)
   );

   // store and arithmetic
   eml_dpath #(
      .EXTENTS     (EXTENTS),
      .BLOCK_SHIFT (BLOCK_SHIFT),
      .IDX_W       (IDX_W)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rd_addr  (rd_addr),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire
